// ===== rtl/dqi_pkg.sv =====
// ----------------------------------------------------------------------------
// dqi_pkg
// Shared codes and types of the indexed double-ended queue: request opcodes,
// result status codes and the command bundle sent to the element store.
// ----------------------------------------------------------------------------
package dqi_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_INSERT     = 3'd5,
    OP_ERASE      = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Per-cycle request to the element store.
  typedef struct packed {
    logic rd_a_en;
    logic rd_b_en;
    logic wr_en;
    logic shift_start;
    logic shift_down;
  } mem_cmd_t;

endpackage

// ===== rtl/dqi_store.sv =====
// ----------------------------------------------------------------------------
// dqi_store
// Element memory with two registered read ports and one write port, plus a
// block-move engine that shifts a run of slots by one place for insert and
// erase. While a move runs, the engine owns read port B and the write port.
// ----------------------------------------------------------------------------
module dqi_store
  import dqi_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mem_cmd_t                        cmd,
  input  logic [$clog2(CAPACITY)-1:0]     rd_a_addr,
  input  logic [$clog2(CAPACITY)-1:0]     rd_b_addr,
  input  logic [$clog2(CAPACITY)-1:0]     wr_addr,
  input  logic [DATA_WIDTH-1:0]           wr_data,
  input  logic [$clog2(CAPACITY)-1:0]     shift_src,
  input  logic [$clog2(CAPACITY)-1:0]     shift_dst,
  input  logic [$clog2(CAPACITY+1)-1:0]   shift_moves,
  output logic [DATA_WIDTH-1:0]           rd_a_data,
  output logic [DATA_WIDTH-1:0]           rd_b_data,
  output logic                            busy
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [AW-1:0] src;
  logic [AW-1:0] dst;
  logic [CW-1:0] left;
  logic          pend;
  logic          down;

  logic                  b_en;
  logic [AW-1:0]         b_addr;
  logic                  w_en;
  logic [AW-1:0]         w_addr;
  logic [DATA_WIDTH-1:0] w_data;

  function automatic logic [AW-1:0] step(input logic [AW-1:0] p, input logic dn);
    logic [AW-1:0] r;
    if (dn) begin
      r = (p == '0) ? LAST : p - AW'(1);
    end else begin
      r = (p == LAST) ? '0 : p + AW'(1);
    end
    return r;
  endfunction

  assign busy = (left != '0) || pend;

  // The engine reads one slot ahead and writes the previous read back one
  // place over.
  always_comb begin
    b_en   = cmd.rd_b_en;
    b_addr = rd_b_addr;
    if (left != '0) begin
      b_en   = 1'b1;
      b_addr = src;
    end
    w_en   = cmd.wr_en;
    w_addr = wr_addr;
    w_data = wr_data;
    if (pend) begin
      w_en   = 1'b1;
      w_addr = dst;
      w_data = rd_b_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_a_en) begin
      rd_a_data <= mem[rd_a_addr];
    end
    if (b_en) begin
      rd_b_data <= mem[b_addr];
    end
    if (w_en) begin
      mem[w_addr] <= w_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      pend <= 1'b0;
    end else if (cmd.shift_start) begin
      left <= shift_moves;
      src  <= shift_src;
      dst  <= shift_dst;
      down <= cmd.shift_down;
      pend <= 1'b0;
    end else begin
      pend <= (left != '0);
      if (left != '0) begin
        left <= left - CW'(1);
        src  <= step(src, down);
      end
      if (pend) begin
        dst <= step(dst, down);
      end
    end
  end

  a_no_wr_clash: assert property (@(posedge clk) disable iff (rst)
    pend |-> !cmd.wr_en)
    else $error("store write requested while a move is writing");

  a_no_rd_clash: assert property (@(posedge clk) disable iff (rst)
    (left != '0) |-> !cmd.rd_b_en)
    else $error("port B read requested while a move is reading");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift_start && (shift_moves != '0)) |=> busy)
    else $error("move with nonzero length did not report busy");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.shift_start)
    else $error("move started while another is running");

endmodule

// ===== rtl/double_ended_queue_indexed.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_indexed
// Fixed-capacity double-ended queue of data words with indexed access.
//
// Requests come in on the req channel (opcode, position, value) and each
// request returns exactly one item on the rsp channel with the word read or
// removed, the front and back words, the element count and a status.
// An item is taken when valid is high and stall is low.
// Pushes, pops, reads, clear and every failed request go from acceptance
// through the DONE state into the result register, and no new request is
// taken before that result is registered.
// Insert and erase move the following elements one slot at a time through
// the block-move engine. When the move ends, insert writes the new word in
// its slot, the FETCH state reads the new front and back words and the DONE
// state loads the result register; no new request is taken meanwhile.
// The result sits in an output register; the next request is taken while it
// waits. If the receiver keeps stalling, a second finished result waits
// inside the block and req_stall stays high until the register frees.
// Reset empties the queue at once; slot contents are not cleared and are
// never read before being written.
// ----------------------------------------------------------------------------
module double_ended_queue_indexed
  import dqi_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  opcode,
  input  logic [10:0] position,
  input  logic [31:0] value,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] read_value,
  output logic [31:0] front_value,
  output logic [31:0] back_value,
  output logic [10:0] element_count,
  output logic [1:0]  status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam int EW = (CW > 11) ? CW : 11;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST  = AW'(CAPACITY - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_FETCH = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                state;
  logic [AW-1:0]         head;
  logic [CW-1:0]         count;
  logic [DATA_WIDTH-1:0] front;
  logic [DATA_WIDTH-1:0] back;
  logic [DATA_WIDTH-1:0] rd_hold;
  logic [DATA_WIDTH-1:0] val_hold;
  logic [AW-1:0]         fin_ptr;
  status_t               sts;
  logic                  ins;
  logic                  rd_mem;
  logic                  front_mem;
  logic                  back_mem;
  logic                  cap_rd;

  op_t                   op;
  logic                  accept;
  logic [63:0]           val_wide;
  logic [DATA_WIDTH-1:0] val_in;
  logic [EW-1:0]         pos_e;
  logic [EW-1:0]         cnt_e;
  logic [CW-1:0]         pos_i;
  logic                  full;
  logic                  empty;
  logic                  pos_ge;
  logic                  pos_gt;
  logic [AW-1:0]         head_dec;
  logic [AW-1:0]         p_tail;
  logic [AW-1:0]         p_last;
  logic [AW-1:0]         p_last2;
  logic [AW-1:0]         p_one;
  logic [AW-1:0]         p_pos;
  logic [AW-1:0]         p_pos1;

  mem_cmd_t              cmd;
  logic [AW-1:0]         rd_a_addr;
  logic [AW-1:0]         rd_b_addr;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [AW-1:0]         sh_src;
  logic [AW-1:0]         sh_dst;
  logic [CW-1:0]         sh_moves;
  logic [DATA_WIDTH-1:0] rd_a_data;
  logic [DATA_WIDTH-1:0] rd_b_data;
  logic                  shift_busy;

  logic [DATA_WIDTH-1:0] rd_sel;
  logic [DATA_WIDTH-1:0] f_sel;
  logic [DATA_WIDTH-1:0] b_sel;
  logic                  out_free;

  // Physical slot of logical element i, counted from the head.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(i);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [31:0] to32(input logic [DATA_WIDTH-1:0] d);
    logic [63:0] w;
    w = 64'(d);
    return w[31:0];
  endfunction

  assign op        = op_t'(opcode);
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign val_wide  = 64'(value);
  assign val_in    = val_wide[DATA_WIDTH-1:0];
  assign pos_e     = EW'(position);
  assign cnt_e     = EW'(count);
  assign pos_i     = CW'(position);
  assign full      = (count == CAP_C);
  assign empty     = (count == '0);
  assign pos_ge    = (pos_e >= cnt_e);
  assign pos_gt    = (pos_e > cnt_e);
  assign head_dec  = (head == '0) ? LAST : head - AW'(1);
  assign p_tail    = phys(head, count);
  assign p_last    = phys(head, count - CW'(1));
  assign p_last2   = phys(head, count - CW'(2));
  assign p_one     = phys(head, CW'(1));
  assign p_pos     = phys(head, pos_i);
  assign p_pos1    = phys(head, pos_i + CW'(1));

  always_comb begin
    cmd       = '0;
    rd_a_addr = head;
    rd_b_addr = p_last;
    wr_addr   = p_tail;
    wr_data   = val_in;
    sh_src    = p_pos1;
    sh_dst    = p_pos;
    sh_moves  = count - CW'(1) - pos_i;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_PUSH_BACK: begin
              cmd.wr_en = !full;
            end
            OP_PUSH_FRONT: begin
              cmd.wr_en = !full;
              wr_addr   = head_dec;
            end
            OP_POP_BACK: begin
              cmd.rd_b_en = (count > CW'(1));
              rd_b_addr   = p_last2;
            end
            OP_POP_FRONT: begin
              cmd.rd_a_en = (count > CW'(1));
              rd_a_addr   = p_one;
            end
            OP_READ: begin
              cmd.rd_a_en = !pos_ge;
              rd_a_addr   = p_pos;
            end
            OP_INSERT: begin
              // Move elements pos..count-1 up by one, starting at the back.
              cmd.shift_start = !pos_gt && !full;
              cmd.shift_down  = 1'b1;
              sh_src          = p_last;
              sh_dst          = p_tail;
              sh_moves        = count - pos_i;
            end
            OP_ERASE: begin
              cmd.rd_a_en     = !empty && !pos_ge;
              rd_a_addr       = p_pos;
              cmd.shift_start = !empty && !pos_ge;
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (!shift_busy && ins) begin
          cmd.wr_en = 1'b1;
          wr_addr   = fin_ptr;
          wr_data   = val_hold;
        end
      end
      S_FETCH: begin
        cmd.rd_a_en = 1'b1;
        cmd.rd_b_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  dqi_store #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rd_a_addr   (rd_a_addr),
    .rd_b_addr   (rd_b_addr),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .shift_src   (sh_src),
    .shift_dst   (sh_dst),
    .shift_moves (sh_moves),
    .rd_a_data   (rd_a_data),
    .rd_b_data   (rd_b_data),
    .busy        (shift_busy)
  );

  assign rd_sel   = rd_mem    ? rd_a_data : rd_hold;
  assign f_sel    = front_mem ? rd_a_data : front;
  assign b_sel    = back_mem  ? rd_b_data : back;
  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
      cap_rd    <= 1'b0;
    end else begin
      cap_rd <= 1'b0;
      // The erased word arrives from read port A in the cycle after acceptance.
      if (cap_rd) begin
        rd_hold <= rd_a_data;
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            rd_hold   <= '0;
            rd_mem    <= 1'b0;
            front_mem <= 1'b0;
            back_mem  <= 1'b0;
            sts       <= ST_OK;
            ins       <= 1'b0;
            val_hold  <= val_in;
            fin_ptr   <= p_pos;
            state     <= S_DONE;
            case (op)
              OP_PUSH_BACK: begin
                if (full) begin
                  sts <= ST_FULL;
                end else begin
                  count <= count + CW'(1);
                  back  <= val_in;
                  if (empty) begin
                    front <= val_in;
                  end
                end
              end
              OP_PUSH_FRONT: begin
                if (full) begin
                  sts <= ST_FULL;
                end else begin
                  head  <= head_dec;
                  count <= count + CW'(1);
                  front <= val_in;
                  if (empty) begin
                    back <= val_in;
                  end
                end
              end
              OP_POP_BACK: begin
                if (empty) begin
                  sts <= ST_EMPTY;
                end else begin
                  rd_hold  <= back;
                  count    <= count - CW'(1);
                  back_mem <= (count > CW'(1));
                end
              end
              OP_POP_FRONT: begin
                if (empty) begin
                  sts <= ST_EMPTY;
                end else begin
                  rd_hold   <= front;
                  head      <= p_one;
                  count     <= count - CW'(1);
                  front_mem <= (count > CW'(1));
                end
              end
              OP_READ: begin
                if (pos_ge) begin
                  sts <= ST_RANGE;
                end else begin
                  rd_mem <= 1'b1;
                end
              end
              OP_INSERT: begin
                if (pos_gt) begin
                  sts <= ST_RANGE;
                end else if (full) begin
                  sts <= ST_FULL;
                end else begin
                  count <= count + CW'(1);
                  ins   <= 1'b1;
                  state <= S_SHIFT;
                end
              end
              OP_ERASE: begin
                if (empty) begin
                  sts <= ST_EMPTY;
                end else if (pos_ge) begin
                  sts <= ST_RANGE;
                end else begin
                  count  <= count - CW'(1);
                  cap_rd <= 1'b1;
                  state  <= S_SHIFT;
                end
              end
              default: begin
                // Clear.
                head  <= '0;
                count <= '0;
              end
            endcase
          end
        end
        S_SHIFT: begin
          if (!shift_busy) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          front_mem <= 1'b1;
          back_mem  <= 1'b1;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid     <= 1'b1;
            read_value    <= to32(rd_sel);
            front_value   <= empty ? 32'd0 : to32(f_sel);
            back_value    <= empty ? 32'd0 : to32(b_sel);
            element_count <= cnt_e[10:0];
            status        <= sts;
            front         <= f_sel;
            back          <= b_sel;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("element count exceeds capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> req_stall)
    else $error("request channel open right after an accepted item");

  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && out_free) |=> (rsp_valid && !req_stall))
    else $error("finished item did not reach the output register");

endmodule
